// File: hw/rtl/skg_pkg.sv
package skg_pkg;

  // default build values
  localparam int unsigned MaxSideDef = 4;
  localparam int unsigned IdWidthDef = 16;

  // side size register
  localparam int unsigned SideW = 3;
  localparam logic [SideW-1:0] SideReset = 3'd2;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

endpackage

// File: hw/rtl/skg_tok_if.sv
interface skg_tok_if
  import skg_pkg::*;
#(
  parameter int unsigned ID_WIDTH = IdWidthDef
);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] token_id;
  logic                sentence_end;

  modport source (output valid, output token_id, output sentence_end, input ready);
  modport sink   (input valid, input token_id, input sentence_end, output ready);
endinterface

// File: hw/rtl/skg_pair_if.sv
interface skg_pair_if
  import skg_pkg::*;
#(
  parameter int unsigned ID_WIDTH = IdWidthDef
);
  logic                valid;
  logic                ready;
  logic [ID_WIDTH-1:0] center_id;
  logic [ID_WIDTH-1:0] context_id;
  logic                run_last;

  modport source (output valid, output center_id, output context_id, output run_last,
                  input ready);
  modport sink   (input valid, input center_id, input context_id, input run_last,
                  output ready);
endinterface

// File: hw/rtl/skipgram_window_pair_generator.sv
// Skip-gram pair generator: takes one token word per accepted handshake and emits
// (center, context) pair words, one per cycle while the output side is ready. A
// mid-sentence token that completes a center gives up to 2*side size pairs, and a
// sentence-end token flushes all pending centers, which is up to
// 3*side size*(side size+1)/2 pairs. The input is held until the last pair of the
// token has been read, and a pair that waits while the output side is not ready
// holds the walk. The pair rate is set by the window memory, which gives one center
// and one context read per cycle while the output register can take a pair; both
// reads are registered. The next token is taken as soon as the last pair of the
// current one has been read, even while that pair still waits in the output
// register. A side size above MAX_SIDE acts as MAX_SIDE, and a side size of zero
// gives no pairs.
module skipgram_window_pair_generator
  import skg_pkg::*;
#(
  parameter int unsigned MAX_SIDE = MaxSideDef,
  parameter int unsigned ID_WIDTH = IdWidthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [SideW-1:0] cfg_wdata_i,
  skg_tok_if.sink          tok_i,
  skg_pair_if.source       pair_o
);

  localparam int unsigned WinDepth = 2 * MAX_SIDE + 1;
  localparam int unsigned AW       = $clog2(WinDepth);
  localparam logic [AW-1:0] PosMax  = AW'(2 * MAX_SIDE);
  localparam logic [AW-1:0] LastAdr = AW'(WinDepth - 1);

  // side size register
  logic [SideW-1:0] side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= SideReset;
    end else if (cfg_we_i) begin
      side_q <= cfg_wdata_i;
    end
  end

  // control state
  state_e        state_q;
  logic [AW-1:0] ptr_q;     // address of the newest token
  logic [AW-1:0] pos_q;     // earlier tokens in this sentence, saturated
  logic [AW-1:0] s_q, n_q, d_q, e_q, d_end_q;
  logic          out_valid_q, run_last_q;
  logic [ID_WIDTH-1:0] center_q, context_q;

  logic [ID_WIDTH-1:0] win_mem [WinDepth];

  // lowest context offset of a center
  function automatic logic [AW-1:0] ctx_lo(logic [AW-1:0] d, logic [AW-1:0] s);
    ctx_lo = (d >= s) ? d - s : '0;
  endfunction

  // first context offset of a center, skipping the center itself
  function automatic logic [AW-1:0] ctx_first(logic [AW-1:0] d, logic [AW-1:0] s,
                                               logic [AW-1:0] n);
    logic [AW:0]   sum;
    logic [AW-1:0] hi;
    sum = {1'b0, d} + {1'b0, s};
    hi  = (sum > {1'b0, n}) ? n : sum[AW-1:0];
    ctx_first = (hi == d) ? d - AW'(1) : hi;
  endfunction

  // window address of an offset back from the newest token
  function automatic logic [AW-1:0] win_adr(logic [AW-1:0] head, logic [AW-1:0] o);
    logic [AW:0] wrap;
    wrap = {1'b0, head} + (AW + 1)'(WinDepth) - {1'b0, o};
    win_adr = (head >= o) ? head - o : wrap[AW-1:0];
  endfunction

  // token accept and pair setup
  logic          accept, last_tok, has_pairs;
  logic [AW-1:0] s_acc, n_acc, d_start, wr_adr;

  assign tok_i.ready = (state_q == ST_IDLE);
  assign accept      = tok_i.valid && tok_i.ready;
  assign last_tok    = tok_i.sentence_end;
  assign wr_adr      = (ptr_q == LastAdr) ? '0 : ptr_q + AW'(1);

  always_comb begin
    s_acc = (side_q > SideW'(MAX_SIDE)) ? AW'(MAX_SIDE) : AW'(side_q);
    n_acc = pos_q;
    if (last_tok) begin
      has_pairs = (s_acc != '0) && (n_acc != '0);
      d_start   = (s_acc < n_acc) ? s_acc : n_acc;
    end else begin
      has_pairs = (s_acc != '0) && (s_acc <= n_acc);
      d_start   = s_acc;
    end
  end

  // pair walk: context offsets descend, then the next lower center
  logic          rd_en, ctr_done, pair_last;
  logic [AW-1:0] e_step, d_next;

  always_comb begin
    rd_en     = (state_q == ST_RUN) && (!out_valid_q || pair_o.ready);
    ctr_done  = (e_q == ctx_lo(d_q, s_q)) || (d_q == '0 && e_q == AW'(1));
    pair_last = ctr_done && (d_q == d_end_q);
    e_step    = (e_q - AW'(1) == d_q) ? e_q - AW'(2) : e_q - AW'(1);
    d_next    = d_q - AW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ptr_q   <= '0;
      pos_q   <= '0;
      s_q     <= '0;
      n_q     <= '0;
      d_q     <= '0;
      e_q     <= '0;
      d_end_q <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            ptr_q   <= wr_adr;
            s_q     <= s_acc;
            n_q     <= n_acc;
            d_q     <= d_start;
            e_q     <= ctx_first(d_start, s_acc, n_acc);
            d_end_q <= last_tok ? '0 : d_start;
            if (last_tok) begin
              pos_q <= '0;
            end else if (pos_q < PosMax) begin
              pos_q <= pos_q + AW'(1);
            end
            if (has_pairs) begin
              state_q <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (rd_en) begin
            if (pair_last) begin
              state_q <= ST_IDLE;
            end else if (ctr_done) begin
              d_q <= d_next;
              e_q <= ctx_first(d_next, s_q, n_q);
            end else begin
              e_q <= e_step;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // token window memory, two registered read ports
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_mem[wr_adr] <= tok_i.token_id;
    end
    if (rd_en) begin
      center_q  <= win_mem[win_adr(ptr_q, d_q)];
      context_q <= win_mem[win_adr(ptr_q, e_q)];
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      run_last_q  <= 1'b0;
    end else if (rd_en) begin
      out_valid_q <= 1'b1;
      run_last_q  <= pair_last;
    end else if (pair_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign pair_o.valid      = out_valid_q;
  assign pair_o.center_id  = center_q;
  assign pair_o.context_id = context_q;
  assign pair_o.run_last   = run_last_q;

`ifndef SYNTHESIS
  // walk never goes past the final center
  a_center_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (d_q >= d_end_q))
    else $error("center offset below final center");

  // a context never equals its own center
  a_ctx_not_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (e_q != d_q))
    else $error("context offset equals center");

  // contexts stay inside the sentence
  a_ctx_in_sentence: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> (e_q <= n_q && d_q <= n_q))
    else $error("offset beyond sentence start");

  // final pair read returns the sequencer to idle with run_last set
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && pair_last) |=> (state_q == ST_IDLE && out_valid_q && run_last_q))
    else $error("final pair did not end the run");
`endif

endmodule
